// File: rtl/mdsp_pkg.sv
// ----------------------------------------------------------------------------
// mdsp_pkg
// Shared types and constants of the slew limited PWM channel block.
// ----------------------------------------------------------------------------
package mdsp_pkg;

  localparam int unsigned DUTY_SCALE = 32766;
  // ceil(2^47 / DUTY_SCALE): the top bits of x * DUTY_RCP from bit 47 up give
  // floor(x / DUTY_SCALE) exactly for every 32-bit x.
  localparam logic [32:0] DUTY_RCP   = 33'd4295229457;
  localparam logic [15:0] SOL_POS    = 16'sd32767;
  localparam logic [15:0] SOL_NEG    = 16'h8001;

  localparam logic [1:0] REG_STEP   = 2'd0;
  localparam logic [1:0] REG_VMIN   = 2'd1;
  localparam logic [1:0] REG_HOLD   = 2'd2;

  localparam logic [1:0] SOL_UNSET  = 2'd0;
  localparam logic [1:0] SOL_OFF    = 2'd1;
  localparam logic [1:0] SOL_ON     = 2'd2;

  // Classified command passed from the front part to the back part.
  typedef struct packed {
    logic [3:0]  channel;
    logic        is_sub;
    logic        is_sol;
    logic [15:0] duty;
    logic [15:0] supply;
    logic [31:0] now_us;
  } mdsp_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [3:0]  out_channel;
    logic [6:0]  pin_a_level;
    logic [6:0]  pin_b_level;
    logic        direction;
    logic [15:0] applied_duty;
  } mdsp_res_t;

endpackage

// File: rtl/mdsp_if.sv
// ----------------------------------------------------------------------------
// mdsp_cmd_if / mdsp_res_if / mdsp_cfg_if
// Valid/ready channels of the block.
// ----------------------------------------------------------------------------
interface mdsp_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel;
  logic [15:0] duty_cmd;
  logic [15:0] supply_mv;
  logic [31:0] now_us;
  modport source (output valid, channel, duty_cmd, supply_mv, now_us, input ready);
  modport sink   (input valid, channel, duty_cmd, supply_mv, now_us, output ready);
endinterface

interface mdsp_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_channel;
  logic [6:0]  pin_a_level;
  logic [6:0]  pin_b_level;
  logic        direction;
  logic [15:0] applied_duty;
  modport source (output valid, out_channel, pin_a_level, pin_b_level, direction,
                  applied_duty, input ready);
  modport sink   (input valid, out_channel, pin_a_level, pin_b_level, direction,
                  applied_duty, output ready);
endinterface

interface mdsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/mdsp_front.sv
// ----------------------------------------------------------------------------
// mdsp_front
// Accepts commands, drops unknown channels, classifies them and feeds a
// two entry queue toward the back part.
// ----------------------------------------------------------------------------
module mdsp_front import mdsp_pkg::*; #(
  parameter int MAIN_CHANNELS = 8,
  parameter int SUB_CHANNELS  = 4
) (
  input  logic       clk,
  input  logic       rst,
  mdsp_cmd_if.sink   cmd,
  output logic       q_valid,
  input  logic       q_pop,
  output mdsp_cmd_t  q_head
);

  localparam int ALL = MAIN_CHANNELS + SUB_CHANNELS;

  mdsp_cmd_t  slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;
  mdsp_cmd_t  item;

  assign cmd.ready = (count != 2'd2);

  // Classify the incoming command.
  always_comb begin
    item.channel = cmd.channel;
    item.is_sub  = (32'(cmd.channel) >= MAIN_CHANNELS);
    item.is_sol  = item.is_sub && (cmd.duty_cmd == SOL_POS || cmd.duty_cmd == SOL_NEG);
    item.duty    = cmd.duty_cmd;
    item.supply  = cmd.supply_mv;
    item.now_us  = cmd.now_us;
  end

  assign push    = cmd.valid && cmd.ready && (32'(cmd.channel) < ALL);
  assign q_valid = (count != 2'd0);
  assign q_head  = slot[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != 2'd0) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");

endmodule

// File: rtl/mdsp_div.sv
// ----------------------------------------------------------------------------
// mdsp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mdsp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [47:0] quo,
  output logic [31:0] rem
);

  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd47;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  // Shift one numerator bit in per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= 32'd0;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[47]};
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/mdsp_back.sv
// ----------------------------------------------------------------------------
// mdsp_back
// Executes one command: slew limit, level computation through the shared
// divider, pin and solenoid state update, and the result register.
// ----------------------------------------------------------------------------
module mdsp_back import mdsp_pkg::*; #(
  parameter int MAIN_CHANNELS = 8,
  parameter int SUB_CHANNELS  = 4,
  parameter int PWM_WRAP      = 124
) (
  input  logic       clk,
  input  logic       rst,
  mdsp_cfg_if.sink   cfg,
  input  logic       q_valid,
  output logic       q_pop,
  input  mdsp_cmd_t  q_head,
  mdsp_res_if.source res
);

  localparam int ALL  = MAIN_CHANNELS + SUB_CHANNELS;
  localparam int SUBN = (SUB_CHANNELS > 0) ? SUB_CHANNELS : 1;
  localparam int SW   = (SUBN > 1) ? $clog2(SUBN) : 1;
  localparam logic [16:0] FULL = 17'(PWM_WRAP + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;
  localparam logic [2:0] ST_RCP  = 3'd6;

  logic [14:0] step_limit;
  logic [15:0] vmin;
  logic [19:0] hold_us;

  logic signed [15:0] last_duty [ALL];
  logic [6:0]  held_a [ALL];
  logic [6:0]  held_b [ALL];
  logic        on_b [SUBN];
  logic [1:0]  sol_st [SUBN];
  logic [31:0] sw_time [SUBN];

  logic [2:0]  state;
  mdsp_cmd_t   cur;
  logic [15:0] s_eff;
  logic signed [15:0] nd;
  logic [15:0] nmag;
  logic [47:0] prod;
  logic [64:0] rq;
  logic        dv_start, dv_done;
  logic [47:0] dv_num, dv_quo;
  logic [31:0] dv_den, dv_rem;
  logic [SW-1:0] sidx;
  logic [16:0] lvl;

  // Derived values of the head command.
  logic [15:0] s_raw;
  logic signed [15:0] prev, hd;
  logic signed [16:0] diff;
  logic [16:0] dmag;
  logic signed [16:0] lim;
  logic signed [15:0] d_app;

  assign cfg.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= 15'd100;
      vmin       <= 16'd22800;
      hold_us    <= 20'd20000;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STEP: step_limit <= cfg.data[14:0];
        REG_VMIN: vmin       <= cfg.data[15:0];
        REG_HOLD: hold_us    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Slew limit and supply floor of the head command.
  always_comb begin
    hd    = q_head.duty;
    prev  = last_duty[q_head.channel];
    diff  = 17'(hd) - 17'(prev);
    dmag  = diff[16] ? -diff : diff;
    lim   = hd < prev ? -$signed({2'b0, step_limit}) : $signed({2'b0, step_limit});
    d_app = (dmag > {2'b0, step_limit}) ? 16'(17'(prev) + lim) : hd;
    s_raw = (q_head.supply < vmin) ? vmin : q_head.supply;
  end

  assign sidx = SW'(32'(cur.channel) - MAIN_CHANNELS);

  mdsp_div u_div (
    .clk (clk), .rst (rst), .start (dv_start), .num (dv_num), .den (dv_den),
    .done (dv_done), .quo (dv_quo), .rem (dv_rem)
  );

  assign res.out_channel  = cur.channel;
  assign res.applied_duty = cur.is_sol ? 16'd0 : nd;

  // Sequencer.
  always_ff @(posedge clk) begin
    logic [31:0] elapsed;
    logic [16:0] c;
    if (rst) begin
      state     <= ST_IDLE;
      q_pop     <= 1'b0;
      dv_start  <= 1'b0;
      res.valid <= 1'b0;
      for (int i = 0; i < ALL; i++) begin
        last_duty[i] <= '0;
        held_a[i] <= (i < MAIN_CHANNELS) ? 7'd0 : FULL[6:0];
        held_b[i] <= (i < MAIN_CHANNELS) ? 7'd0 : FULL[6:0];
      end
      for (int i = 0; i < SUBN; i++) begin
        on_b[i] <= 1'b0;
        sol_st[i] <= SOL_UNSET;
        sw_time[i] <= '0;
      end
    end else begin
      q_pop    <= 1'b0;
      dv_start <= 1'b0;
      if (res.valid && res.ready) res.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid && !q_pop && !res.valid) begin
            q_pop <= 1'b1;
            cur   <= q_head;
            s_eff <= (s_raw == 16'd0) ? 16'd1 : s_raw;
            nd    <= d_app;
            nmag  <= d_app[15] ? 16'(-d_app) : d_app;
            if (q_head.is_sol) begin
              elapsed = q_head.now_us - sw_time[SW'(32'(q_head.channel) - MAIN_CHANNELS)];
              if (elapsed >= {12'd0, hold_us}) state <= ST_OUT;
            end else if (hd != prev) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          // Main: FULL*|d| / 32766, then * vmin / s.  Sub: FULL minus FULL*|d|*vmin / (32766*s), rounded up.
          prod  <= 48'(FULL) * 48'(nmag);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          if (cur.is_sub) begin
            dv_num   <= 48'(prod[31:0]) * 48'(vmin) + 48'(DUTY_SCALE * s_eff) - 48'd1;
            dv_den   <= 32'(DUTY_SCALE) * 32'(s_eff);
            dv_start <= 1'b1;
            state    <= ST_DIV1;
          end else begin
            // Division by the fixed duty scale through its reciprocal.
            rq    <= 65'(prod[31:0]) * 65'(DUTY_RCP);
            state <= ST_RCP;
          end
        end
        ST_RCP: begin
          dv_num   <= 48'(rq[63:47]) * 48'(vmin);
          dv_den   <= 32'(s_eff);
          dv_start <= 1'b1;
          state    <= ST_DIV2;
        end
        ST_DIV1: begin
          if (dv_done) begin
            c = (dv_quo >= 48'(FULL)) ? FULL : dv_quo[16:0];
            lvl <= FULL - c;
            state <= ST_OUT;
          end
        end
        ST_DIV2: begin
          if (dv_done) begin
            lvl   <= dv_quo[16:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          res.valid <= 1'b1;
          state     <= ST_IDLE;
          res.direction <= 1'b0;
          if (cur.is_sol) begin
            if (sol_st[sidx] == (cur.duty[15] ? SOL_OFF : SOL_ON)) begin
              res.pin_a_level <= FULL[6:0];
              res.pin_b_level <= FULL[6:0];
              held_a[cur.channel] <= FULL[6:0];
              held_b[cur.channel] <= FULL[6:0];
            end else begin
              res.pin_a_level <= cur.duty[15] ? 7'd0 : FULL[6:0];
              res.pin_b_level <= cur.duty[15] ? FULL[6:0] : 7'd0;
              held_a[cur.channel] <= cur.duty[15] ? 7'd0 : FULL[6:0];
              held_b[cur.channel] <= cur.duty[15] ? FULL[6:0] : 7'd0;
              sw_time[sidx] <= cur.now_us;
              sol_st[sidx]  <= cur.duty[15] ? SOL_OFF : SOL_ON;
            end
          end else if (!cur.is_sub) begin
            held_a[cur.channel] <= lvl[6:0];
            held_b[cur.channel] <= 7'd0;
            last_duty[cur.channel] <= nd;
            res.pin_a_level <= lvl[6:0];
            res.pin_b_level <= 7'd0;
            res.direction   <= nd[15];
          end else begin
            logic pb;
            logic [6:0] na, nb;
            logic signed [15:0] pv;
            pv = last_duty[cur.channel];
            pb = on_b[sidx];
            na = held_a[cur.channel];
            nb = held_b[cur.channel];
            if ((nd <= 0 && pv >= 0) || (nd >= 0 && pv <= 0)) begin
              if (nd > 0) begin
                pb = 1'b0;
                nb = FULL[6:0];
              end else if (nd < 0) begin
                pb = 1'b1;
                na = FULL[6:0];
              end
            end
            if (pb) nb = lvl[6:0];
            else na = lvl[6:0];
            on_b[sidx] <= pb;
            held_a[cur.channel] <= na;
            held_b[cur.channel] <= nb;
            last_duty[cur.channel] <= nd;
            res.pin_a_level <= na;
            res.pin_b_level <= nb;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> $past(state) == ST_IDLE) else $error("pop outside idle");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |=> res.valid) else $error("result not raised");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    dv_start |-> state == ST_DIV1 || state == ST_DIV2) else $error("divider misuse");

endmodule

// File: rtl/motor_duty_slew_pwm_channels.sv
// ----------------------------------------------------------------------------
// motor_duty_slew_pwm_channels
// Slew limited PWM driver with supply compensation for main and sub channels.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// cmd      in   channel, duty_cmd, supply_mv, now_us
// res      out  out_channel, pin_a_level, pin_b_level, direction, applied_duty
// cfg      in   index, data (step limit, min supply, solenoid hold)
//
// A main channel command goes through a reciprocal multiply and one 48-step
// division, a sub channel command through one division, and a solenoid or
// repeated command through neither. Reset is synchronous and restores all
// channel state. A two entry queue buffers up to two commands while the
// result register waits on a stalled sink.
module motor_duty_slew_pwm_channels import mdsp_pkg::*; #(
  parameter int MAIN_CHANNELS = 8,
  parameter int SUB_CHANNELS  = 4,
  parameter int PWM_WRAP      = 124
) (
  input logic        clk,
  input logic        rst,
  mdsp_cmd_if.sink   cmd,
  mdsp_res_if.source res,
  mdsp_cfg_if.sink   cfg
);

  logic      q_valid, q_pop;
  mdsp_cmd_t q_head;

  mdsp_front #(.MAIN_CHANNELS(MAIN_CHANNELS), .SUB_CHANNELS(SUB_CHANNELS)) u_front (
    .clk (clk), .rst (rst), .cmd (cmd),
    .q_valid (q_valid), .q_pop (q_pop), .q_head (q_head)
  );

  mdsp_back #(.MAIN_CHANNELS(MAIN_CHANNELS), .SUB_CHANNELS(SUB_CHANNELS),
              .PWM_WRAP(PWM_WRAP)) u_back (
    .clk (clk), .rst (rst), .cfg (cfg),
    .q_valid (q_valid), .q_pop (q_pop), .q_head (q_head), .res (res)
  );

endmodule

// File: verif/mdsp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mdsp_checker
// Watches the command, configuration and result channels of the PWM block,
// predicts each result from its own copy of the channel state and compares
// the outputs field by field in order.
// ----------------------------------------------------------------------------
module mdsp_checker import mdsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mdsp_cmd_if.sink    cmd,
  mdsp_res_if.sink    res,
  mdsp_cfg_if.sink    cfg,
  output int          fail_count,
  output int          pending_count
);

  localparam int MAINS = 8;
  localparam int SUBS  = 4;
  localparam int ALL   = MAINS + SUBS;
  localparam longint FULL = 125;

  // Configuration copy.
  logic [14:0] step_lim;
  logic [15:0] vmin;
  logic [19:0] hold_us;

  // Channel state copy.
  logic signed [15:0] prev_duty [ALL];
  logic [6:0]  lvl_a [ALL];
  logic [6:0]  lvl_b [ALL];
  logic        on_b [SUBS];
  logic [1:0]  sol_st [SUBS];
  logic [31:0] sol_time [SUBS];

  mdsp_res_t expected_q[$];

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic reset_state();
    step_lim = 15'd100;
    vmin = 16'd22800;
    hold_us = 20'd20000;
    for (int i = 0; i < ALL; i++) begin
      prev_duty[i] = '0;
      lvl_a[i] = (i < MAINS) ? 7'd0 : 7'(FULL);
      lvl_b[i] = (i < MAINS) ? 7'd0 : 7'(FULL);
    end
    for (int i = 0; i < SUBS; i++) begin
      on_b[i] = 1'b0;
      sol_st[i] = SOL_UNSET;
      sol_time[i] = '0;
    end
  endtask

  // Works out the result of one command transaction, if it causes one.
  task automatic predict_pwm(input logic [3:0] ch, input logic signed [15:0] cmd_duty,
                             input logic [15:0] sup, input logic [31:0] now);
    longint d, p, diff, mag, s, q, num, den, c, lv;
    int sb;
    logic [1:0] want;
    mdsp_res_t r;
    if (ch >= ALL) return;
    d = cmd_duty;
    s = (sup < vmin) ? vmin : sup;
    if (s == 0) s = 1;
    r = '0;
    r.out_channel = ch;
    if (ch >= MAINS && (d == 32767 || d == -32767)) begin
      sb = ch - MAINS;
      want = (d > 0) ? SOL_ON : SOL_OFF;
      if (32'(now - sol_time[sb]) < {12'd0, hold_us}) return;
      if (sol_st[sb] == want) begin
        lvl_a[ch] = 7'(FULL);
        lvl_b[ch] = 7'(FULL);
      end else begin
        lvl_a[ch] = (want == SOL_ON) ? 7'(FULL) : 7'd0;
        lvl_b[ch] = (want == SOL_ON) ? 7'd0 : 7'(FULL);
        sol_time[sb] = now;
        sol_st[sb] = want;
      end
      r.pin_a_level = lvl_a[ch];
      r.pin_b_level = lvl_b[ch];
      expected_q.push_back(r);
      return;
    end
    p = prev_duty[ch];
    if (d == p) return;
    diff = d - p;
    mag = diff < 0 ? -diff : diff;
    if (mag > step_lim) d = p + ((d < p) ? -longint'(step_lim) : longint'(step_lim));
    mag = d < 0 ? -d : d;
    r.applied_duty = 16'(d);
    if (ch < MAINS) begin
      q = (FULL * mag) / DUTY_SCALE;
      lvl_a[ch] = 7'((q * vmin) / s);
      lvl_b[ch] = 7'd0;
      prev_duty[ch] = 16'(d);
      r.pin_a_level = lvl_a[ch];
      r.direction = d < 0;
      expected_q.push_back(r);
      return;
    end
    sb = ch - MAINS;
    num = FULL * mag * vmin;
    den = DUTY_SCALE * s;
    c = (num + den - 1) / den;
    lv = (c >= FULL) ? 0 : FULL - c;
    // A pin is chosen only when the duty crosses or leaves zero.
    if ((d <= 0 && p >= 0) || (d >= 0 && p <= 0)) begin
      if (d > 0) begin
        on_b[sb] = 1'b0;
        lvl_b[ch] = 7'(FULL);
      end else if (d < 0) begin
        on_b[sb] = 1'b1;
        lvl_a[ch] = 7'(FULL);
      end
    end
    if (on_b[sb]) lvl_b[ch] = 7'(lv);
    else lvl_a[ch] = 7'(lv);
    prev_duty[ch] = 16'(d);
    r.pin_a_level = lvl_a[ch];
    r.pin_b_level = lvl_b[ch];
    expected_q.push_back(r);
  endtask

  // Sample all channels at the rising edge.
  always @(posedge clk) begin
    mdsp_res_t w;
    if (rst) begin
      reset_state();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_STEP: step_lim = cfg.data[14:0];
          REG_VMIN: vmin = cfg.data[15:0];
          REG_HOLD: hold_us = cfg.data;
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result transaction on channel %0d", $realtime,
                   res.out_channel);
          fail_count++;
        end else begin
          w = expected_q.pop_front();
          if (res.out_channel != w.out_channel)
            report("out_channel", res.out_channel, w.out_channel);
          if (res.pin_a_level != w.pin_a_level)
            report("pin_a_level", res.pin_a_level, w.pin_a_level);
          if (res.pin_b_level != w.pin_b_level)
            report("pin_b_level", res.pin_b_level, w.pin_b_level);
          if (res.direction != w.direction)
            report("direction", res.direction, w.direction);
          if (res.applied_duty != w.applied_duty)
            report("applied_duty", $signed(res.applied_duty), $signed(w.applied_duty));
        end
      end
      if (cmd.valid && cmd.ready)
        predict_pwm(cmd.channel, cmd.duty_cmd, cmd.supply_mv, cmd.now_us);
    end
    pending_count = expected_q.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random duty commands, supply values and timestamps
// into the PWM block across several register settings, with random stalls on
// both sides, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import mdsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  logic res_hold = 1'b0;
  logic quiet_tail = 1'b0;
  logic [31:0] clock_us = '0;

  mdsp_cmd_if cmd_ch ();
  mdsp_res_if res_ch ();
  mdsp_cfg_if cfg_ch ();

  motor_duty_slew_pwm_channels dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch.sink), .res(res_ch.source), .cfg(cfg_ch.sink)
  );

  mdsp_checker checker_i (
    .clk(clk), .rst(rst), .cmd(cmd_ch.sink), .res(res_ch.sink), .cfg(cfg_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #2 clk = ~clk;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.channel = '0;
    cmd_ch.duty_cmd = '0;
    cmd_ch.supply_mv = '0;
    cmd_ch.now_us = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  // Result side: random stall bursts, none in the tail, long hold on request.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (res_hold || (!quiet_tail && $urandom_range(0, 5) == 0)) begin
        n = res_hold ? 1 : $urandom_range(1, 4);
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else if (!res_hold)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Leaves valid high after the transaction; the next command or a drain
  // decides what follows.
  task automatic send_cmd(input logic [3:0] ch, input logic [15:0] duty,
                          input logic [15:0] sup, input logic [31:0] now);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.channel <= ch;
    cmd_ch.duty_cmd <= duty;
    cmd_ch.supply_mv <= sup;
    cmd_ch.now_us <= now;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Waits until all results are in, then lets the block finish silent work.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_duty();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 400)) - 200);
      2: return $urandom_range(0, 1) ? 16'sd32766 : -16'sd32766;
      3: return $urandom_range(0, 1) ? SOL_POS : SOL_NEG;
      4: return 16'h8000;
      default: return 16'($urandom_range(0, 65535)) >>> $urandom_range(0, 10);
    endcase
  endfunction

  function automatic logic [15:0] rand_supply();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(20000, 30000));
      default: return 16'($urandom_range(0, 1) ? 16'hFFFF : 16'd0);
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [3:0] ch;
    for (int i = 0; i < count; i++) begin
      ch = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(0, 11));
      clock_us = clock_us + $urandom_range(0, 30000);
      if ($urandom_range(0, 15) == 0) clock_us = $urandom;
      send_cmd(ch, rand_duty(), rand_supply(), clock_us);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, repeats, zero crossings, solenoid hold-off.
    send_cmd(4'd0, 16'sd32767, 16'd0, 32'd0);
    send_cmd(4'd0, 16'sd32767, 16'hFFFF, 32'd0);
    send_cmd(4'd0, 16'sd0, 16'd22800, 32'd0);
    send_cmd(4'd0, 16'sd0, 16'd22800, 32'd0);
    send_cmd(4'd7, 16'h8000, 16'd30000, 32'd0);
    send_cmd(4'd8, 16'sd50, 16'd22800, 32'd0);
    send_cmd(4'd8, -16'sd50, 16'd22800, 32'd0);
    send_cmd(4'd8, -16'sd50, 16'd22800, 32'd0);
    send_cmd(4'd9, SOL_POS, 16'd22800, 32'd100);
    send_cmd(4'd9, SOL_POS, 16'd22800, 32'd20000);
    send_cmd(4'd9, SOL_POS, 16'd22800, 32'd40000);
    send_cmd(4'd9, SOL_NEG, 16'd22800, 32'hFFFF_FFF0);
    send_cmd(4'd12, 16'sd100, 16'd22800, 32'd0);
    send_cmd(4'd15, SOL_POS, 16'hFFFF, 32'hFFFF_FFFF);
    drain();

    // Extreme settings: full step, zero reference, no hold-off.
    write_reg(REG_STEP, 20'd32767);
    write_reg(REG_VMIN, 20'd0);
    write_reg(REG_HOLD, 20'd0);
    send_cmd(4'd1, 16'sd32767, 16'd0, 32'd0);
    send_cmd(4'd1, 16'h8000, 16'd0, 32'd0);
    send_cmd(4'd10, 16'sd32766, 16'd0, 32'd0);
    send_cmd(4'd10, -16'sd32766, 16'd0, 32'd0);
    send_cmd(4'd11, SOL_NEG, 16'd5, 32'd0);
    send_cmd(4'd11, SOL_NEG, 16'd5, 32'd0);
    random_phase(150);
    drain();

    // Smallest step, largest reference and hold.
    write_reg(REG_STEP, 20'd1);
    write_reg(REG_VMIN, 20'd65535);
    write_reg(REG_HOLD, 20'hFFFFF);
    random_phase(150);
    drain();

    // Long result stall with commands still offered.
    write_reg(REG_STEP, 20'd4000);
    write_reg(REG_VMIN, 20'd22800);
    write_reg(REG_HOLD, 20'd15000);
    fork
      random_phase(30);
      begin
        res_hold = 1'b1;
        repeat (1500) @(posedge clk);
        res_hold = 1'b0;
      end
    join
    random_phase(120);
    drain();

    write_reg(REG_STEP, 20'($urandom_range(1, 32767)));
    write_reg(REG_VMIN, 20'($urandom_range(1, 65535)));
    write_reg(REG_HOLD, 20'($urandom_range(0, 1000000)));
    random_phase(150);

    // Tail without any idling.
    quiet_tail = 1'b1;
    random_phase(130);
    drain();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
